// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the yaw torque vectoring checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define YTV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define YTV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ytv_pkg.sv -----
// ----------------------------------------------------------------------------
// ytv_pkg
// Types, constants and helper functions of the yaw torque vectoring block.
// ----------------------------------------------------------------------------
package ytv_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_GAIN    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_DB      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_LIMIT   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ACCEL   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_FRAC  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_THR  = 4'd7;

    // Fixed deadbands on the sensor inputs, Q8.8 magnitude
    localparam logic [16:0] STEER_DEADBAND   = 17'd512;
    localparam logic [16:0] LATERAL_DEADBAND = 17'd128;
    localparam logic [16:0] LONG_DEADBAND    = 17'd128;

    // Pipeline stages
    localparam int NUM_STAGES = 5;
    localparam int ST_GATE = 0;   // enable gate and input deadbands
    localparam int ST_MUL1 = 1;   // first products
    localparam int ST_RND1 = 2;   // round, saturate, error deadband
    localparam int ST_MUL2 = 3;   // second products
    localparam int ST_OUT  = 4;   // final saturation and limit, output word

    typedef struct packed {
        logic signed [15:0] steer_to_yaw_gain;
        logic signed [15:0] lateral_gain;
        logic signed [15:0] yaw_feedback_gain;
        logic [14:0]        yaw_error_deadband;
        logic [14:0]        yaw_command_limit;
        logic [15:0]        inverse_max_accel;
        logic [15:0]        front_reduction_fraction;
        logic [14:0]        enable_threshold;
    } t_cfg;

    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;   // stage register loads this cycle
    } t_pipe_ctrl;

    // Saturate to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] res;
        if (v > 32'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Magnitude of a signed 16-bit value, 17 bits so -32768 fits
    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        return v[15] ? unsigned'(-w) : unsigned'(w);
    endfunction

    // Pass value unless gated off or its magnitude is strictly below the deadband
    function automatic logic signed [15:0] db_pass(input logic signed [15:0] v,
                                                   input logic [16:0]        db,
                                                   input logic               en);
        return (!en || (mag17(v) < db)) ? 16'sd0 : v;
    endfunction

endpackage

// ----- hw/rtl/yaw_torque_vectoring_command_top.sv -----
// ----------------------------------------------------------------------------
// yaw_torque_vectoring_command_top
// Yaw moment command and front torque reduction from one sensor sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one word per sample with
//   longitudinal and lateral accel, steering angle, yaw rate and torque
//   command. A word is taken on a rising edge with valid high, stall low.
//   Output channel (o_out_valid / i_out_stall): one result word per sample,
//   yaw moment command and front reduction, in sample order.
//   Config channel (i_cfg_valid / o_cfg_ready): ready is always high; write
//   the eight registers only while no sample is in flight.
//   Pipeline: five register stages (gate, multiply, round, multiply, limit)
//   lie between the accepting edge and o_out_valid.
//   Throughput: one sample per cycle while the output is not stalled;
//   each stage holds one word.
//   Stall: a stalled result holds its stage, upstream stages keep filling
//   empty slots, and o_in_stall rises once every stage is occupied.
//   Reset: all valid bits clear and config registers return to their reset values.
// ----------------------------------------------------------------------------
module yaw_torque_vectoring_command_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Sample input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [15:0]            i_long_accel,
    input  logic signed [15:0]            i_lat_accel,
    input  logic signed [15:0]            i_steering_angle,
    input  logic signed [15:0]            i_yaw_rate,
    input  logic [14:0]                   i_torque_command,
    // Result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [15:0]            o_yaw_moment_command,
    output logic [15:0]                   o_front_reduction,
    // Configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ytv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import ytv_pkg::*;

    t_cfg       cfg;
    t_pipe_ctrl ctrl;

    // Hold the register file; it feeds both datapaths directly
    ytv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Advance every stage that is empty or whose word moves downstream
    ytv_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctrl      (ctrl)
    );

    // Yaw moment: gain products, error deadband, sum and symmetric limit
    ytv_yaw_path u_yaw (
        .i_clk                (i_clk),
        .i_cfg                (cfg),
        .i_ctrl               (ctrl),
        .i_lat_accel          (i_lat_accel),
        .i_steering_angle     (i_steering_angle),
        .i_yaw_rate           (i_yaw_rate),
        .i_torque_command     (i_torque_command),
        .o_yaw_moment_command (o_yaw_moment_command)
    );

    // Front reduction: normalize accel, clamp to one, scale by fraction
    ytv_accel_path u_accel (
        .i_clk             (i_clk),
        .i_cfg             (cfg),
        .i_ctrl            (ctrl),
        .i_long_accel      (i_long_accel),
        .i_torque_command  (i_torque_command),
        .o_front_reduction (o_front_reduction)
    );

endmodule

// ----- hw/rtl/ytv_cfg.sv -----
// ----------------------------------------------------------------------------
// ytv_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module ytv_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ytv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    output ytv_pkg::t_cfg                  o_cfg
);
    import ytv_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STEER_GAIN: n_cfg.steer_to_yaw_gain        = signed'(i_cfg_data);
                REG_LAT_GAIN:   n_cfg.lateral_gain             = signed'(i_cfg_data);
                REG_FB_GAIN:    n_cfg.yaw_feedback_gain        = signed'(i_cfg_data);
                REG_ERR_DB:     n_cfg.yaw_error_deadband       = i_cfg_data[14:0];
                REG_CMD_LIMIT:  n_cfg.yaw_command_limit        = i_cfg_data[14:0];
                REG_INV_ACCEL:  n_cfg.inverse_max_accel        = i_cfg_data;
                REG_FRONT_FRAC: n_cfg.front_reduction_fraction = i_cfg_data;
                REG_ENABLE_THR: n_cfg.enable_threshold         = i_cfg_data[14:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steer_to_yaw_gain        <= 16'sd256;
            r_cfg.lateral_gain             <= 16'sd0;
            r_cfg.yaw_feedback_gain        <= 16'sd0;
            r_cfg.yaw_error_deadband       <= 15'd256;
            r_cfg.yaw_command_limit        <= 15'd2560;
            r_cfg.inverse_max_accel        <= 16'd4369;
            r_cfg.front_reduction_fraction <= 16'd0;
            r_cfg.enable_threshold         <= 15'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- hw/rtl/ytv_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// ytv_pipe_ctrl
// Valid bits and per-stage advance chain of the five-stage pipeline.
// ----------------------------------------------------------------------------
module ytv_pipe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ytv_pkg::t_pipe_ctrl o_ctrl
);
    import ytv_pkg::*;

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_v;
    logic [NUM_STAGES-1:0] adv;

    // A stage loads when it is empty or its content moves on
    always_comb begin
        adv[ST_OUT] = !r_v[ST_OUT] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_comb begin
        n_v = r_v;
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                n_v[k] = (k == 0) ? i_in_valid : r_v[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ctrl.adv  = adv;
    assign o_in_stall  = !adv[ST_GATE];
    assign o_out_valid = r_v[ST_OUT];

endmodule

// ----- hw/rtl/ytv_yaw_path.sv -----
// ----------------------------------------------------------------------------
// ytv_yaw_path
// Yaw moment datapath: feedforward on lateral accel plus yaw error feedback.
// ----------------------------------------------------------------------------
module ytv_yaw_path (
    input  logic                i_clk,
    input  ytv_pkg::t_cfg       i_cfg,
    input  ytv_pkg::t_pipe_ctrl i_ctrl,
    input  logic signed [15:0]  i_lat_accel,
    input  logic signed [15:0]  i_steering_angle,
    input  logic signed [15:0]  i_yaw_rate,
    input  logic [14:0]         i_torque_command,
    output logic signed [15:0]  o_yaw_moment_command
);
    import ytv_pkg::*;

    // Gate stage
    logic               r_en_s0,    n_en_s0;
    logic signed [15:0] r_steer_s0, n_steer_s0;
    logic signed [15:0] r_ay_s0,    n_ay_s0;
    logic signed [15:0] r_yaw_s0;
    // First products
    logic               r_en_s1;
    logic signed [31:0] r_tgt_p_s1, n_tgt_p_s1;
    logic signed [31:0] r_ff_p_s1,  n_ff_p_s1;
    logic signed [15:0] r_yaw_s1;
    // Round and error
    logic signed [15:0] r_err_s2,   n_err_s2;
    logic signed [15:0] r_ff_s2,    n_ff_s2;
    // Second product
    logic signed [31:0] r_fb_p_s3,  n_fb_p_s3;
    logic signed [15:0] r_ff_s3;
    // Output
    logic signed [15:0] r_cmd_s4,   n_cmd_s4;

    logic signed [15:0] tgt;
    logic signed [15:0] fb;
    logic signed [15:0] sum;
    logic signed [16:0] lim;

    always_comb begin
        n_en_s0    = i_torque_command >= i_cfg.enable_threshold;
        n_steer_s0 = db_pass(i_steering_angle, STEER_DEADBAND, n_en_s0);
        n_ay_s0    = db_pass(i_lat_accel, LATERAL_DEADBAND, n_en_s0);
    end

    always_comb begin
        n_tgt_p_s1 = 32'(i_cfg.steer_to_yaw_gain) * 32'(r_steer_s0);
        n_ff_p_s1  = 32'(i_cfg.lateral_gain) * 32'(r_ay_s0);
    end

    // Floor to Q8.8 is an arithmetic shift
    always_comb begin
        tgt      = sat16(r_tgt_p_s1 >>> 8);
        n_err_s2 = sat16(32'(tgt) - 32'(r_yaw_s1));
        n_err_s2 = db_pass(n_err_s2, {2'b00, i_cfg.yaw_error_deadband}, r_en_s1);
        n_ff_s2  = sat16(r_ff_p_s1 >>> 8);
    end

    always_comb begin
        n_fb_p_s3 = 32'(i_cfg.yaw_feedback_gain) * 32'(r_err_s2);
    end

    always_comb begin
        fb  = sat16(r_fb_p_s3 >>> 8);
        sum = sat16(32'(r_ff_s3) + 32'(fb));
        lim = signed'({2'b00, i_cfg.yaw_command_limit});
        if (17'(sum) > lim) begin
            n_cmd_s4 = lim[15:0];
        end else if (17'(sum) < -lim) begin
            n_cmd_s4 = 16'(-lim);
        end else begin
            n_cmd_s4 = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv[ST_GATE]) begin
            r_en_s0    <= n_en_s0;
            r_steer_s0 <= n_steer_s0;
            r_ay_s0    <= n_ay_s0;
            r_yaw_s0   <= i_yaw_rate;
        end
        if (i_ctrl.adv[ST_MUL1]) begin
            r_en_s1    <= r_en_s0;
            r_tgt_p_s1 <= n_tgt_p_s1;
            r_ff_p_s1  <= n_ff_p_s1;
            r_yaw_s1   <= r_yaw_s0;
        end
        if (i_ctrl.adv[ST_RND1]) begin
            r_err_s2 <= n_err_s2;
            r_ff_s2  <= n_ff_s2;
        end
        if (i_ctrl.adv[ST_MUL2]) begin
            r_fb_p_s3 <= n_fb_p_s3;
            r_ff_s3   <= r_ff_s2;
        end
        if (i_ctrl.adv[ST_OUT]) begin
            r_cmd_s4 <= n_cmd_s4;
        end
    end

    assign o_yaw_moment_command = r_cmd_s4;

endmodule

// ----- hw/rtl/ytv_accel_path.sv -----
// ----------------------------------------------------------------------------
// ytv_accel_path
// Front torque reduction from normalized positive longitudinal acceleration.
// ----------------------------------------------------------------------------
module ytv_accel_path (
    input  logic                i_clk,
    input  ytv_pkg::t_cfg       i_cfg,
    input  ytv_pkg::t_pipe_ctrl i_ctrl,
    input  logic signed [15:0]  i_long_accel,
    input  logic [14:0]         i_torque_command,
    output logic [15:0]         o_front_reduction
);
    import ytv_pkg::*;

    localparam logic [30:0] NORM_ONE = 31'h100_0000;   // 1.0 in Q.24

    logic               n_en_s0;
    logic signed [15:0] r_ax_s0,     n_ax_s0;
    logic [30:0]        r_norm_p_s1, n_norm_p_s1;
    logic [16:0]        r_norm_s2,   n_norm_s2;
    logic [31:0]        r_red_p_s3,  n_red_p_s3;
    logic [15:0]        r_red_s4;

    always_comb begin
        n_en_s0 = i_torque_command >= i_cfg.enable_threshold;
        n_ax_s0 = db_pass(i_long_accel, LONG_DEADBAND, n_en_s0);
    end

    // Only a positive acceleration reduces front torque
    always_comb begin
        if (r_ax_s0 > 16'sd0) begin
            n_norm_p_s1 = 31'(r_ax_s0[14:0]) * 31'(i_cfg.inverse_max_accel);
        end else begin
            n_norm_p_s1 = '0;
        end
    end

    // Clamp to one, then drop to Q.16
    always_comb begin
        if (r_norm_p_s1 > NORM_ONE) begin
            n_norm_s2 = NORM_ONE[24:8];
        end else begin
            n_norm_s2 = r_norm_p_s1[24:8];
        end
    end

    always_comb begin
        n_red_p_s3 = 32'(i_cfg.front_reduction_fraction) * 32'(r_norm_s2);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv[ST_GATE]) begin
            r_ax_s0 <= n_ax_s0;
        end
        if (i_ctrl.adv[ST_MUL1]) begin
            r_norm_p_s1 <= n_norm_p_s1;
        end
        if (i_ctrl.adv[ST_RND1]) begin
            r_norm_s2 <= n_norm_s2;
        end
        if (i_ctrl.adv[ST_MUL2]) begin
            r_red_p_s3 <= n_red_p_s3;
        end
        if (i_ctrl.adv[ST_OUT]) begin
            r_red_s4 <= r_red_p_s3[31:16];
        end
    end

    assign o_front_reduction = r_red_s4;

endmodule

// ----- hw/rtl/ytv_checker.sv -----
// ----------------------------------------------------------------------------
// ytv_checker
// Port-level assertions on the yaw torque vectoring block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ytv_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_yaw_moment_command,
    input logic [15:0]        o_front_reduction
);

    // Hold a stalled result word
    `YTV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result word dropped while stalled")

    `YTV_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_yaw_moment_command) && $stable(o_front_reduction), "stalled result word changed")

    // An empty output slot lets the whole pipeline advance
    `YTV_ASSERT_IMPL(a_no_stall_when_empty, i_clk, i_rst_n, !o_out_valid, !o_in_stall, "input stalled with output stage empty")

    // Symmetric limit never reaches the most negative code
    `YTV_ASSERT_IMPL(a_cmd_symmetric, i_clk, i_rst_n, o_out_valid, o_yaw_moment_command != 16'sh8000, "yaw command outside symmetric limit")

endmodule

bind yaw_torque_vectoring_command_top ytv_checker u_ytv_checker (.*);
